// ===== hdl/npcl1_pkg.sv =====
package npcl1_pkg;

	// Field widths of the item and result channels.
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned DIST_W  = 10;

	// Default palette depth handed down from the top level.
	localparam int unsigned DEFAULT_PALETTE_DEPTH = 256;

	// Item opcodes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_en;     // store the item's color in the palette
		logic start;     // latch the pixel and the active count, clear the best
		logic rd_issue;  // read the entry at the scan address and advance it
		logic out_load;  // move the finished result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;  // the active count is zero: pass the pixel through
		logic last_addr;   // the scan address is the last active entry
		logic out_free;    // the output register can take a result this cycle
	} status_t;

endpackage

// ===== hdl/npcl1_if.sv =====
interface npcl1_item_if import npcl1_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [INDEX_W-1:0] entry_index;
	logic [COLOR_W-1:0] red_in;
	logic [COLOR_W-1:0] green_in;
	logic [COLOR_W-1:0] blue_in;

	modport source (output valid, opcode, entry_index, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, opcode, entry_index, red_in, green_in, blue_in,
		output ready);
endinterface

interface npcl1_result_if import npcl1_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] red_out;
	logic [COLOR_W-1:0] green_out;
	logic [COLOR_W-1:0] blue_out;
	logic [INDEX_W-1:0] color_index;
	logic [DIST_W-1:0]  best_distance;
	logic               matched;

	modport source (output valid, red_out, green_out, blue_out, color_index,
		best_distance, matched, input ready);
	modport sink (input valid, red_out, green_out, blue_out, color_index,
		best_distance, matched, output ready);
endinterface

// ===== hdl/npcl1_ctrl.sv =====
module npcl1_ctrl import npcl1_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_opcode,
	output logic    item_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_opcode == OP_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start  = 1'b1;
						state_next = status.count_zero ? ST_DONE : ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				cmd.rd_issue = 1'b1;
				if (status.last_addr) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last entry read is compared in this cycle.
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== hdl/npcl1_datapath.sv =====
module npcl1_datapath import npcl1_pkg::*; #(
	parameter int unsigned PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [COLOR_W-1:0] red_in,
	input  logic [COLOR_W-1:0] green_in,
	input  logic [COLOR_W-1:0] blue_in,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] red_out,
	output logic [COLOR_W-1:0] green_out,
	output logic [COLOR_W-1:0] blue_out,
	output logic [INDEX_W-1:0] color_index,
	output logic [DIST_W-1:0]  best_distance,
	output logic               matched
);

	localparam int unsigned AW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int unsigned IW   = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int unsigned DW_C = $clog2(PALETTE_DEPTH + 1);
	localparam int unsigned CW   = (DW_C > COUNT_W) ? DW_C : COUNT_W;
	localparam int unsigned RGB_W = 3 * COLOR_W;

	logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];

	logic [COUNT_W-1:0] palette_count_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      addr_q;
	logic [COLOR_W-1:0] pix_r_q, pix_g_q, pix_b_q;
	logic               search_q;

	logic [RGB_W-1:0]   rd_data_s1;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;

	logic               have_q;
	logic [DIST_W-1:0]  best_sum_q;
	logic [AW-1:0]      best_idx_q;
	logic [RGB_W-1:0]   best_rgb_q;

	logic               out_valid_q;

	logic [IW-1:0]      wr_idx_w;
	logic               wr_in_range;
	logic [CW-1:0]      cnt_w;
	logic [CW-1:0]      cnt_eff;
	logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
	logic [DIST_W-1:0]  entry_sum;
	logic               take;
	logic [IW-1:0]      best_idx_w;

	assign wr_idx_w    = IW'(entry_index);
	assign wr_in_range = {1'b0, wr_idx_w} < (IW + 1)'(PALETTE_DEPTH);

	// A count above the depth searches the whole palette.
	assign cnt_w   = CW'(palette_count_q);
	assign cnt_eff = (cnt_w > CW'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH) : cnt_w;

	assign status.count_zero = (palette_count_q == '0);
	assign status.last_addr  = (CW'(addr_q) == (count_q - CW'(1)));
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_count_q <= '0;
		end else if (cfg_we) begin
			palette_count_q <= cfg_wdata;
		end
	end

	// Palette memory: one write port for write items, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_in_range) begin
			palette_mem[wr_idx_w[AW-1:0]] <= {red_in, green_in, blue_in};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_data_s1 <= palette_mem[addr_q];
		end
		rd_idx_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			addr_q    <= '0;
			have_q    <= 1'b0;
			search_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.start) begin
				addr_q   <= '0;
				have_q   <= 1'b0;
				search_q <= !status.count_zero;
			end else begin
				if (cmd.rd_issue) begin
					addr_q <= addr_q + AW'(1);
				end
				if (take) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pix_r_q <= red_in;
			pix_g_q <= green_in;
			pix_b_q <= blue_in;
			count_q <= cnt_eff;
		end
	end

	// L1 distance of the entry just read, and the running minimum.
	assign diff_r = (pix_r_q > rd_data_s1[RGB_W-1 -: COLOR_W])
		? pix_r_q - rd_data_s1[RGB_W-1 -: COLOR_W]
		: rd_data_s1[RGB_W-1 -: COLOR_W] - pix_r_q;
	assign diff_g = (pix_g_q > rd_data_s1[2*COLOR_W-1 -: COLOR_W])
		? pix_g_q - rd_data_s1[2*COLOR_W-1 -: COLOR_W]
		: rd_data_s1[2*COLOR_W-1 -: COLOR_W] - pix_g_q;
	assign diff_b = (pix_b_q > rd_data_s1[COLOR_W-1:0])
		? pix_b_q - rd_data_s1[COLOR_W-1:0]
		: rd_data_s1[COLOR_W-1:0] - pix_b_q;
	assign entry_sum = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);

	// Strictly smaller only, so the lowest index wins a tie.
	assign take = rd_vld_s1 && (!have_q || (entry_sum < best_sum_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_sum_q <= entry_sum;
			best_idx_q <= rd_idx_s1;
			best_rgb_q <= rd_data_s1;
		end
	end

	assign best_idx_w = IW'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (search_q) begin
				red_out       <= best_rgb_q[RGB_W-1 -: COLOR_W];
				green_out     <= best_rgb_q[2*COLOR_W-1 -: COLOR_W];
				blue_out      <= best_rgb_q[COLOR_W-1:0];
				color_index   <= best_idx_w[INDEX_W-1:0];
				best_distance <= best_sum_q;
				matched       <= 1'b1;
			end else begin
				red_out       <= pix_r_q;
				green_out     <= pix_g_q;
				blue_out      <= pix_b_q;
				color_index   <= '0;
				best_distance <= '0;
				matched       <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/nearest_palette_color_l1.sv =====
// Nearest palette color by L1 distance. A write item (opcode 0) stores one RGB entry at
// entry_index in the palette memory and gives no result; a pixel item (opcode 1) gives one
// result: the entry below palette_count with the smallest sum of absolute channel
// differences, the lowest index winning a tie, together with its index and distance. With
// palette_count at zero the pixel passes through with matched low. A pixel item scans the
// active entries, reading one palette entry per cycle through the single read port of the
// palette memory; a drain state then finishes the last compare, and a done state moves the
// result into the output register once that is free. With the count at zero the scan and
// drain are skipped. The output register holds a result until it is taken, while the block
// already accepts the next item. Write palette_count only while the block is idle; entries
// searched must have been written first.
module nearest_palette_color_l1 import npcl1_pkg::*; #(
	parameter int unsigned PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [COUNT_W-1:0]   cfg_wdata,
	npcl1_item_if.sink           item,
	npcl1_result_if.source       result
);

	// Commands and status between the controller and the datapath.
	cmd_t    cmd;
	status_t status;

	// The controller sequences each item: write items go straight to the memory, pixel items
	// run a scan over the active entries and then wait for the output register to be free.
	npcl1_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_opcode (item.opcode),
		.item_ready  (item.ready),
		.status      (status),
		.cmd         (cmd)
	);

	// The datapath holds the count register, the palette memory, the distance compare, the
	// running best entry and the output register of the result channel.
	npcl1_datapath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.entry_index   (item.entry_index),
		.red_in        (item.red_in),
		.green_in      (item.green_in),
		.blue_in       (item.blue_in),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.red_out       (result.red_out),
		.green_out     (result.green_out),
		.blue_out      (result.blue_out),
		.color_index   (result.color_index),
		.best_distance (result.best_distance),
		.matched       (result.matched)
	);

endmodule

// ===== hdl/npcl1_checker.sv =====
module npcl1_checker import npcl1_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [COLOR_W-1:0] res_red,
	input logic [COLOR_W-1:0] res_green,
	input logic [COLOR_W-1:0] res_blue,
	input logic [INDEX_W-1:0] res_index,
	input logic [DIST_W-1:0]  res_dist,
	input logic               res_matched
);

	// A result that waits is not withdrawn.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped before transfer");

	// A result that waits keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({res_red, res_green, res_blue, res_index,
			res_dist, res_matched}))
		else $error("result payload changed before transfer");

	// A pass-through result carries index and distance zero.
	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_matched |-> res_index == '0 && res_dist == '0)
		else $error("unmatched result with nonzero index or distance");

	// An L1 distance over three 8-bit channels never exceeds 765.
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_dist <= DIST_W'(765))
		else $error("distance out of range");

endmodule

bind nearest_palette_color_l1 npcl1_checker u_npcl1_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_red     (result.red_out),
	.res_green   (result.green_out),
	.res_blue    (result.blue_out),
	.res_index   (result.color_index),
	.res_dist    (result.best_distance),
	.res_matched (result.matched)
);

// ===== dv/nearest_palette_color_l1_test.sv =====
`timescale 1ns / 100ps

module nearest_palette_color_l1_test;
	import npcl1_pkg::*;

	// The palette depth of the block under test. Counts above it saturate.
	localparam int PALETTE_SLOTS = DEFAULT_PALETTE_DEPTH;

	// The run stops here if it has not ended on its own. The slowest correct run
	// (about a thousand transfers, every one a full scan of the palette with the longest
	// gaps and stalls on both sides) stays well below this figure.
	localparam int CYCLE_LIMIT = 1_500_000;

	// Cycles that the result side holds off once so that the block backs up.
	localparam int HOLD_CYCLES = 400;

	// Cycles allowed after the last result for a palette write still in flight.
	localparam int SETTLE_CYCLES = 8;

	// Number of random transfers to send after the directed tests.
	localparam int RANDOM_ITEMS = 400;

	// Only this many mismatches are printed; the rest are just counted.
	localparam int REPORT_LIMIT = 50;

	// One expected result: the chosen color, its index, its distance and the match flag.
	typedef struct {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [INDEX_W-1:0] index;
		logic [DIST_W-1:0]  distance;
		logic               matched;
	} color_match_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;

	npcl1_item_if   item_bus ();
	npcl1_result_if result_bus ();

	nearest_palette_color_l1 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_bus),
		.result    (result_bus)
	);

	// The clock runs with an 8 ns period.
	always #4 clk = ~clk;

	// Our own copy of the palette and of the active count. A slot is marked once it
	// has been written, so that no pixel is ever sent while the search would cover
	// a slot that was never written.
	logic [3*COLOR_W-1:0] palette_model [PALETTE_SLOTS];
	bit                   slot_written  [PALETTE_SLOTS];
	int                   active_count;

	// Results that have been predicted but have not yet come out of the block, oldest first.
	color_match_t pending_matches [$];

	int error_count;
	bit idle_on;
	bit hold_active;
	event hold_start;

	function automatic int channel_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// Works out the result of one pixel: a linear scan over the active slots that keeps
	// the first slot with the strictly smallest L1 distance, so the lowest index wins a
	// tie. With no active slot the pixel passes through unmatched.
	function automatic color_match_t nearest_color(logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		color_match_t match;
		int entry_sum;
		int low_sum;
		int best_slot;
		match.red = r;
		match.green = g;
		match.blue = b;
		match.index = '0;
		match.distance = '0;
		match.matched = 1'b0;
		if (active_count == 0) begin
			return match;
		end
		low_sum = 1 << 20;
		best_slot = 0;
		for (int i = 0; i < active_count; i++) begin
			entry_sum = channel_gap(r, palette_model[i][23:16])
				+ channel_gap(g, palette_model[i][15:8])
				+ channel_gap(b, palette_model[i][7:0]);
			if (entry_sum < low_sum) begin
				low_sum = entry_sum;
				best_slot = i;
			end
		end
		{match.red, match.green, match.blue} = palette_model[best_slot];
		match.index = INDEX_W'(best_slot);
		match.distance = DIST_W'(low_sum);
		match.matched = 1'b1;
		return match;
	endfunction

	// Offers one item and returns at the clock edge where the transfer takes place.
	// With idling on, the sender now and then drops valid for a burst of cycles first.
	// Valid stays high between back-to-back items, so each time step sees at most one
	// assignment to it.
	task automatic send_item(input logic op, input logic [INDEX_W-1:0] slot,
			input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 15);
		end
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.opcode <= op;
		item_bus.entry_index <= slot;
		item_bus.red_in <= r;
		item_bus.green_in <= g;
		item_bus.blue_in <= b;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		// The transfer happened at this edge: update the palette copy or predict the pixel.
		if (op == OP_WRITE) begin
			palette_model[slot] = {r, g, b};
			slot_written[slot] = 1'b1;
		end else begin
			pending_matches.push_back(nearest_color(r, g, b));
		end
	endtask

	// Stops offering items and waits until every predicted result has come out, then
	// gives a trailing palette write time to land. Afterwards the block is idle.
	task automatic wait_drained();
		item_bus.valid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the active count while the block is idle. Values above the depth saturate.
	task automatic set_count(input int value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= COUNT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = (value > PALETTE_SLOTS) ? PALETTE_SLOTS : value;
	endtask

	// Writes a random color into every slot below the given bound that is still unwritten,
	// so that a following count of that size only searches written slots.
	task automatic fill_palette(input int bound);
		int top;
		top = (bound > PALETTE_SLOTS) ? PALETTE_SLOTS : bound;
		for (int i = 0; i < top; i++) begin
			if (!slot_written[i]) begin
				send_item(OP_WRITE, INDEX_W'(i), COLOR_W'($urandom), COLOR_W'($urandom),
					COLOR_W'($urandom));
			end
		end
	endtask

	task automatic send_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		send_item(OP_PIXEL, INDEX_W'($urandom), r, g, b);
	endtask

	// With no active slot every pixel passes through unmatched, at both color extremes.
	// A palette write in this mode gives no result.
	task automatic test_passthrough();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_item(OP_WRITE, 8'd200, 8'h12, 8'h34, 8'h56);
		send_pixel(8'h55, 8'hAA, 8'h0F);
		send_pixel(8'hA5, 8'h5A, 8'hF0);
		wait_drained();
	endtask

	// One active slot at one corner of the cube and the pixel at the other gives the
	// largest distance, 765; an exact hit gives zero.
	task automatic test_distance_extremes();
		send_item(OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
		set_count(1);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		wait_drained();
	endtask

	// Slot 1 duplicates slot 0, and slots 2 and 3 sit at equal distance on either side,
	// so several pixels land on a tie that the lowest index must win.
	task automatic test_tie_break();
		send_item(OP_WRITE, 8'd0, 8'd100, 8'd100, 8'd100);
		send_item(OP_WRITE, 8'd1, 8'd100, 8'd100, 8'd100);
		send_item(OP_WRITE, 8'd2, 8'd110, 8'd100, 8'd100);
		send_item(OP_WRITE, 8'd3, 8'd90, 8'd100, 8'd100);
		set_count(4);
		send_pixel(8'd100, 8'd100, 8'd100);
		send_pixel(8'd105, 8'd100, 8'd100);
		send_pixel(8'd95, 8'd100, 8'd100);
		send_pixel(8'd120, 8'd100, 8'd100);
		send_pixel(8'd80, 8'd100, 8'd100);
		// Slot 2 and slot 3 now tie at the far end while slot 0 and slot 1 are farther.
		send_item(OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0);
		send_item(OP_WRITE, 8'd1, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd100, 8'd100, 8'd100);
		wait_drained();
	endtask

	// Fills the whole palette and searches all of it, with the count at the depth and
	// with counts above the depth, which must saturate.
	task automatic test_full_palette();
		send_item(OP_WRITE, 8'd255, 8'd1, 8'd2, 8'd3);
		fill_palette(PALETTE_SLOTS);
		set_count(PALETTE_SLOTS);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		set_count((1 << COUNT_W) - 1);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'h80, 8'h7F, 8'h01);
		set_count(PALETTE_SLOTS + 1);
		send_pixel(8'd1, 8'd2, 8'd3);
		wait_drained();
	endtask

	// The result side holds off for a long stretch while pixels keep coming, so the
	// output register fills up and the block has to stall its input.
	task automatic test_backpressure();
		fill_palette(4);
		set_count(4);
		-> hold_start;
		for (int i = 0; i < 12; i++) begin
			send_pixel(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
		end
		wait_drained();
	endtask

	function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		return (v < 0) ? '0 : (v > 255) ? '1 : COLOR_W'(v);
	endfunction

	// Random traffic in phases. Each phase picks a count (mostly small, sometimes zero,
	// sometimes the full depth or above), then sends a mix of pixels and palette writes.
	// Many pixels sit close to an active slot so that near ties and exact hits are common.
	task automatic test_random_traffic();
		int sent;
		int phase_len;
		int pick;
		int count_value;
		int slot;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				count_value = 0;
			end else if (pick == 1) begin
				count_value = PALETTE_SLOTS;
			end else if (pick == 2) begin
				count_value = $urandom_range(PALETTE_SLOTS + 1, (1 << COUNT_W) - 1);
			end else if (pick < 10) begin
				count_value = $urandom_range(1, 8);
			end else begin
				count_value = $urandom_range(1, 48);
			end
			// The last stretch runs with no idling on either side.
			if (sent >= RANDOM_ITEMS - 60) begin
				idle_on = 1'b0;
			end
			fill_palette(count_value);
			set_count(count_value);
			// Full scans are slow, so those phases are kept short.
			phase_len = (active_count > 64) ? $urandom_range(4, 10) : $urandom_range(15, 35);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 9) < 3) begin
					// A palette write, either inside the active range or anywhere.
					if (active_count > 0 && $urandom_range(0, 1) == 1) begin
						slot = $urandom_range(0, active_count - 1);
					end else begin
						slot = $urandom_range(0, PALETTE_SLOTS - 1);
					end
					send_item(OP_WRITE, INDEX_W'(slot), COLOR_W'($urandom),
						COLOR_W'($urandom), COLOR_W'($urandom));
				end else begin
					pick = $urandom_range(0, 15);
					if (pick == 0) begin
						send_pixel(8'h00, 8'h00, 8'h00);
					end else if (pick == 1) begin
						send_pixel(8'hFF, 8'hFF, 8'hFF);
					end else if (pick < 9 && active_count > 0) begin
						slot = $urandom_range(0, active_count - 1);
						send_pixel(nudge(palette_model[slot][23:16]),
							nudge(palette_model[slot][15:8]), nudge(palette_model[slot][7:0]));
					end else begin
						send_pixel(COLOR_W'($urandom), COLOR_W'($urandom),
							COLOR_W'($urandom));
					end
				end
				sent++;
			end
		end
		wait_drained();
	endtask

	// Stimulus: reset once, then the tests in turn, then the verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_bus.valid <= 1'b0;
		item_bus.opcode <= OP_WRITE;
		item_bus.entry_index <= '0;
		item_bus.red_in <= '0;
		item_bus.green_in <= '0;
		item_bus.blue_in <= '0;
		active_count = 0;
		error_count = 0;
		idle_on = 1'b1;
		foreach (slot_written[i]) begin
			slot_written[i] = 1'b0;
			palette_model[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_distance_extremes();
		test_tie_break();
		test_full_palette();
		test_backpressure();
		test_random_traffic();

		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// A single long hold-off on the result side, counted here in cycles.
	initial begin
		hold_active <= 1'b0;
		forever begin
			@(hold_start);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	task automatic check_field(input string field, input logic [DIST_W-1:0] want,
			input logic [DIST_W-1:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
			end
		end
	endtask

	// Result side: each transfer is compared field by field with the oldest prediction.
	// Ready drops in random stall bursts while idling is on, and for the long hold-off.
	initial begin
		int stall_left;
		color_match_t want;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				if (pending_matches.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("%0t: result with no pixel pending: expected none actual %0d/%0d/%0d",
							$time, result_bus.red_out, result_bus.green_out, result_bus.blue_out);
					end
				end else begin
					want = pending_matches.pop_front();
					check_field("red_out", DIST_W'(want.red), DIST_W'(result_bus.red_out));
					check_field("green_out", DIST_W'(want.green),
						DIST_W'(result_bus.green_out));
					check_field("blue_out", DIST_W'(want.blue), DIST_W'(result_bus.blue_out));
					check_field("color_index", DIST_W'(want.index),
						DIST_W'(result_bus.color_index));
					check_field("best_distance", want.distance, result_bus.best_distance);
					check_field("matched", DIST_W'(want.matched),
						DIST_W'(result_bus.matched));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			result_bus.ready <= arst_n && !hold_active && stall_left == 0;
		end
	end

	// Watchdog: a run that has not finished by the limit counts as a failure.
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule
